### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// types, constants and helpers for the speed command line parser
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int BUFFER_BYTES_DEF = 64;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_Y     = 8'h79;
    localparam logic [7:0] CHAR_O     = 8'h6F;

    // "_speed:" shared by all three literals
    localparam logic [7:0] LIT_TAIL [7] = '{8'h5F, 8'h73, 8'h70, 8'h65, 8'h65, 8'h64, 8'h3A};

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_LIT_X = 3'd0,
        ST_NUM_X = 3'd1,
        ST_LIT_Y = 3'd2,
        ST_NUM_Y = 3'd3,
        ST_LIT_O = 3'd4,
        ST_NUM_O = 3'd5,
        ST_DONE  = 3'd6
    } stage_t;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic signed [31:0] rot_value;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic [7:0] lit_char(input stage_t s, input logic [2:0] pos);
        logic [7:0] head;
        head = (s == ST_LIT_X) ? CHAR_X : ((s == ST_LIT_Y) ? CHAR_Y : CHAR_O);
        return (pos == 3'd0) ? head : LIT_TAIL[3'(pos - 3'd1)];
    endfunction

    function automatic logic [31:0] number_value(input logic neg, input logic [31:0] mag);
        if (neg) begin
            return 32'(32'd0 - mag);
        end
        return mag[31] ? POS_MAX : mag;
    endfunction

endpackage

### hdl/speed_command_line_parser_top.sv
// ----------------------------------------------------------------------------
// speed_command_line_parser_top
// parses "x_speed:N y_speed:N o_speed:N" text lines from received bytes
//
//   channel  | ports                                   | item
//   ---------+-----------------------------------------+---------------------
//   input    | s_valid s_ready s_rx_byte               | one received byte
//   result   | m_valid m_ready m_x/y/rot_value         | one matched line
//
// one byte accepted per cycle while a held result does not stall it; m_valid
// rises once the line-ending byte has passed the input register, then the result register
// the parser update (times-ten add and literal compare) sits between the two
// synchronous active-low reset; no clearing pass, ready the cycle after reset
// a stalled result holds the input register only when it has a byte waiting
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module speed_command_line_parser_top #(
    parameter int BUFFER_BYTES = scp_pkg::BUFFER_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_x_value,
    output logic signed [31:0] m_y_value,
    output logic signed [31:0] m_rot_value
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg, in_byte_next;
    logic             out_free;
    logic             step;
    logic             res_valid;
    logic             out_load;
    scp_pkg::result_t res_data;
    scp_pkg::result_t out_data;

    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign out_load = step && res_valid;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (step) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
    end

    scp_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    scp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .load_data (res_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (out_data),
        .free      (out_free)
    );

    assign m_x_value   = out_data.x_value;
    assign m_y_value   = out_data.y_value;
    assign m_rot_value = out_data.rot_value;

    `ASSERT_SAME(a_load_into_free, out_load, out_free, "result loaded over a held result")
    `ASSERT_SAME(a_result_on_eol, res_valid,
        step && (in_byte_reg == scp_pkg::CHAR_LF || in_byte_reg == scp_pkg::CHAR_CR),
        "result raised without a line end")
    `ASSERT_NEXT(a_held_byte_kept, in_valid_reg && !step,
        in_valid_reg && $stable(in_byte_reg), "waiting item lost or changed")

endmodule

### hdl/scp_parser.sv
// ----------------------------------------------------------------------------
// scp_parser
// line parser state and the per-byte update, one byte per enabled cycle
// ----------------------------------------------------------------------------
module scp_parser #(
    parameter int BUFFER_BYTES = scp_pkg::BUFFER_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output scp_pkg::result_t  res_data
);

    localparam int CHARS_W = $clog2(BUFFER_BYTES);
    localparam logic [CHARS_W-1:0] CHARS_MAX = CHARS_W'(BUFFER_BYTES - 1);

    scp_pkg::stage_t    stage_reg, stage_next;
    logic [2:0]         lit_pos_reg, lit_pos_next;
    scp_pkg::phase_t    phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [31:0]        accum_reg, accum_next;
    logic [31:0]        first_reg, first_next;
    logic [31:0]        second_reg, second_next;
    logic               failed_reg, failed_next;
    logic [CHARS_W-1:0] chars_reg, chars_next;
    logic               cut_reg, cut_next;

    logic        eol;
    logic        ws;
    logic        digit;
    logic [35:0] acc_sum;
    logic [31:0] acc_sat;
    logic [31:0] cur_value;
    logic [7:0]  next_lit_head;

    assign eol     = (rx_byte == scp_pkg::CHAR_LF) || (rx_byte == scp_pkg::CHAR_CR);
    assign ws      = scp_pkg::is_ws(rx_byte);
    assign digit   = scp_pkg::is_digit(rx_byte);
    // times ten as two shifts plus the new digit
    assign acc_sum = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                   + {32'd0, 4'(rx_byte - scp_pkg::CHAR_ZERO)};
    assign acc_sat = (acc_sum > {4'd0, scp_pkg::MAG_CAP}) ? scp_pkg::MAG_CAP : acc_sum[31:0];
    assign cur_value     = scp_pkg::number_value(neg_reg, accum_reg);
    assign next_lit_head = (stage_reg == scp_pkg::ST_NUM_X) ? scp_pkg::CHAR_Y : scp_pkg::CHAR_O;

    // next state
    always_comb begin
        stage_next   = stage_reg;
        lit_pos_next = lit_pos_reg;
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        accum_next   = accum_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        failed_next  = failed_reg;
        chars_next   = chars_reg;
        cut_next     = cut_reg;
        if (step_en) begin
            if (eol) begin
                if (chars_reg != '0) begin
                    stage_next   = scp_pkg::ST_LIT_X;
                    lit_pos_next = 3'd0;
                    phase_next   = scp_pkg::PH_SKIP;
                    neg_next     = 1'b0;
                    accum_next   = 32'd0;
                    first_next   = 32'd0;
                    second_next  = 32'd0;
                    failed_next  = 1'b0;
                    chars_next   = '0;
                    cut_next     = 1'b0;
                end
            end else if (chars_reg < CHARS_MAX) begin
                chars_next = chars_reg + 1'b1;
                if (!cut_reg && !failed_reg) begin
                    if (rx_byte == scp_pkg::CHAR_NUL) begin
                        cut_next = 1'b1;
                    end else begin
                        case (stage_reg)
                            scp_pkg::ST_LIT_X, scp_pkg::ST_LIT_Y, scp_pkg::ST_LIT_O: begin
                                if (stage_reg != scp_pkg::ST_LIT_X && lit_pos_reg == 3'd0
                                        && ws) begin
                                    stage_next = stage_reg;
                                end else if (rx_byte == scp_pkg::lit_char(stage_reg,
                                                                         lit_pos_reg)) begin
                                    lit_pos_next = lit_pos_reg + 3'd1;
                                    if (lit_pos_reg == 3'd7) begin
                                        stage_next = scp_pkg::stage_t'(stage_reg + 3'd1);
                                        phase_next = scp_pkg::PH_SKIP;
                                        neg_next   = 1'b0;
                                        accum_next = 32'd0;
                                    end
                                end else begin
                                    failed_next = 1'b1;
                                end
                            end
                            scp_pkg::ST_NUM_X, scp_pkg::ST_NUM_Y, scp_pkg::ST_NUM_O: begin
                                case (phase_reg)
                                    scp_pkg::PH_SKIP: begin
                                        if (ws) begin
                                            phase_next = scp_pkg::PH_SKIP;
                                        end else if (rx_byte == scp_pkg::CHAR_PLUS
                                                || rx_byte == scp_pkg::CHAR_MINUS) begin
                                            neg_next   = (rx_byte == scp_pkg::CHAR_MINUS);
                                            phase_next = scp_pkg::PH_SIGN;
                                        end else if (digit) begin
                                            accum_next = acc_sat;
                                            phase_next = scp_pkg::PH_DIGITS;
                                        end else begin
                                            failed_next = 1'b1;
                                        end
                                    end
                                    scp_pkg::PH_SIGN: begin
                                        if (digit) begin
                                            accum_next = acc_sat;
                                            phase_next = scp_pkg::PH_DIGITS;
                                        end else begin
                                            failed_next = 1'b1;
                                        end
                                    end
                                    default: begin
                                        if (digit) begin
                                            accum_next = acc_sat;
                                        end else if (stage_reg == scp_pkg::ST_NUM_O) begin
                                            stage_next = scp_pkg::ST_DONE;
                                        end else begin
                                            if (stage_reg == scp_pkg::ST_NUM_X) begin
                                                first_next = cur_value;
                                            end else begin
                                                second_next = cur_value;
                                            end
                                            stage_next   = scp_pkg::stage_t'(stage_reg + 3'd1);
                                            lit_pos_next = 3'd0;
                                            // a non-blank ending byte starts the next literal
                                            if (!ws) begin
                                                if (rx_byte == next_lit_head) begin
                                                    lit_pos_next = 3'd1;
                                                end else begin
                                                    failed_next = 1'b1;
                                                end
                                            end
                                        end
                                    end
                                endcase
                            end
                            default: begin
                                stage_next = stage_reg;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // result of a completed line
    always_comb begin
        res_valid = step_en && eol && (chars_reg != '0) && !failed_reg
                 && ((stage_reg == scp_pkg::ST_DONE)
                  || (stage_reg == scp_pkg::ST_NUM_O && phase_reg == scp_pkg::PH_DIGITS));
        res_data.x_value   = first_reg;
        res_data.y_value   = second_reg;
        res_data.rot_value = cur_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg   <= scp_pkg::ST_LIT_X;
            lit_pos_reg <= 3'd0;
            phase_reg   <= scp_pkg::PH_SKIP;
            neg_reg     <= 1'b0;
            accum_reg   <= 32'd0;
            first_reg   <= 32'd0;
            second_reg  <= 32'd0;
            failed_reg  <= 1'b0;
            chars_reg   <= '0;
            cut_reg     <= 1'b0;
        end else begin
            stage_reg   <= stage_next;
            lit_pos_reg <= lit_pos_next;
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            accum_reg   <= accum_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            failed_reg  <= failed_next;
            chars_reg   <= chars_next;
            cut_reg     <= cut_next;
        end
    end

endmodule

### hdl/scp_out_buf.sv
// ----------------------------------------------------------------------------
// scp_out_buf
// result register holding one parsed line until the sink takes it
// ----------------------------------------------------------------------------
module scp_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  scp_pkg::result_t  load_data,
    input  logic              m_ready,
    output logic              m_valid,
    output scp_pkg::result_t  m_data,
    output logic              free
);

    logic             valid_reg, valid_next;
    scp_pkg::result_t data_reg, data_next;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

### tb/sv/speed_command_line_parser_top_tb.sv
// ----------------------------------------------------------------------------
// speed_command_line_parser_top_tb
// self-checking bench for the speed command line parser. received bytes are
// sent as whole text lines: first a table of hand-picked lines, then random
// lines, mostly well-formed commands with random numbers, whitespace and line
// ends, the rest broken commands, long lines, raw noise and empty lines. each
// accepted byte goes through a bench-side parser, and every speed result that
// comes out is compared field by field with the oldest expected one. pacing
// runs through several sender and receiver idle mixes and a long result stall.
// ----------------------------------------------------------------------------
module speed_command_line_parser_top_tb;

    localparam int BUF_BYTES    = scp_pkg::BUFFER_BYTES_DEF;
    localparam int ITEMS        = 1750;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 20;
    localparam int NUM_ROWS     = 20;
    localparam logic [7:0] NO_POKE = 8'hFF;

    typedef struct packed {
        logic        typed;
        logic [7:0]  poke_at;
        logic [7:0]  poke_val;
        logic [31:0] want_x;
        logic [31:0] want_y;
        logic [31:0] want_rot;
    } row_info_t;

    logic               aclk;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte   = 8'h00;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic signed [31:0] m_x_value;
    logic signed [31:0] m_y_value;
    logic signed [31:0] m_rot_value;

    // bench-side parser state
    scp_pkg::stage_t ln_stage;
    logic [2:0]      ln_lit_pos;
    scp_pkg::phase_t ln_phase;
    logic            ln_neg;
    logic [31:0]     ln_mag;
    logic [31:0]     ln_x;
    logic [31:0]     ln_y;
    logic            ln_failed;
    int              ln_count;
    logic            ln_cut;

    scp_pkg::result_t pending_speeds[$];
    logic [7:0]       line_buf[$];
    logic             typed_active = 1'b0;
    scp_pkg::result_t typed_want;

    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    int fail_count        = 0;
    int bytes_sent        = 0;
    int bytes_counted     = 0;
    int lines_sent        = 0;
    int results_predicted = 0;
    int results_checked   = 0;

    string row_text [NUM_ROWS] = '{
        "x_speed:1 y_speed:2 o_speed:3\n",
        "x_speed:2147483647 y_speed:-2147483648 o_speed:+0\r",
        "x_speed:99999999999 y_speed:-2147483649 o_speed:2147483648\n",
        "x_speed:-0 y_speed:+00012 o_speed:-7 trailing text\n",
        "x_speed:\t5\vy_speed:\f-6 \t o_speed: 7\r\n",
        "x_speed:5y_speed:6o_speed:7\n",
        "x_speed:12 y_speed:34 o_speed:\n",
        "x_speed:+ y_speed:1 o_speed:1\n",
        "x_speed:- 1 y_speed:1 o_speed:1\r",
        " x_speed:1 y_speed:2 o_speed:3\n",
        "x_speed :1 y_speed:2 o_speed:3\n",
        "x_speed:1 y_spied:2 o_speed:3\n",
        "\r\n\n",
        "x_speed:1 y_speed:2 o_speed:45#99\n",
        "x_speed:1 y_#peed:2 o_speed:3\n",
        "x_speed:1 y_speed:2 o_speed:#\n",
        "x_speed:1 y_speed:2 o_speed:3#\n",
        "x_speed:1 y_speed:2                              o_speed:123456789\n",
        "x_speed:0 y_speed:0 o_speed:0\n",
        "x_speed:-1 y_speed:-2 o_speed:-3+\r"
    };

    row_info_t row_info [NUM_ROWS] = '{
        {1'b1, NO_POKE, 8'h00, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003},
        {1'b1, NO_POKE, 8'h00, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
        {1'b1, NO_POKE, 8'h00, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
        {1'b1, NO_POKE, 8'h00, 32'h0000_0000, 32'h0000_000C, 32'hFFFF_FFF9},
        {1'b1, NO_POKE, 8'h00, 32'h0000_0005, 32'hFFFF_FFFA, 32'h0000_0007},
        {1'b1, NO_POKE, 8'h00, 32'h0000_0005, 32'h0000_0006, 32'h0000_0007},
        {1'b0, NO_POKE, 8'h00, 32'h0, 32'h0, 32'h0},
        {1'b0, NO_POKE, 8'h00, 32'h0, 32'h0, 32'h0},
        {1'b0, NO_POKE, 8'h00, 32'h0, 32'h0, 32'h0},
        {1'b0, NO_POKE, 8'h00, 32'h0, 32'h0, 32'h0},
        {1'b0, NO_POKE, 8'h00, 32'h0, 32'h0, 32'h0},
        {1'b0, NO_POKE, 8'h00, 32'h0, 32'h0, 32'h0},
        {1'b0, NO_POKE, 8'h00, 32'h0, 32'h0, 32'h0},
        {1'b1, 8'd30, scp_pkg::CHAR_NUL, 32'h0000_0001, 32'h0000_0002, 32'h0000_002D},
        {1'b0, 8'd12, scp_pkg::CHAR_NUL, 32'h0, 32'h0, 32'h0},
        {1'b0, 8'd28, 8'hFF, 32'h0, 32'h0, 32'h0},
        {1'b0, 8'd29, 8'h80, 32'h0, 32'h0, 32'h0},
        {1'b0, NO_POKE, 8'h00, 32'h0, 32'h0, 32'h0},
        {1'b1, NO_POKE, 8'h00, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        {1'b1, NO_POKE, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD}
    };

    speed_command_line_parser_top #(
        .BUFFER_BYTES (BUF_BYTES)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_x_value   (m_x_value),
        .m_y_value   (m_y_value),
        .m_rot_value (m_rot_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == scp_pkg::CHAR_SPACE || c == scp_pkg::CHAR_TAB
            || c == scp_pkg::CHAR_VT || c == scp_pkg::CHAR_FF;
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= scp_pkg::CHAR_ZERO && c <= scp_pkg::CHAR_NINE;
    endfunction

    function automatic logic [7:0] literal_at(input scp_pkg::stage_t stg,
                                              input logic [2:0] pos);
        string word;
        case (stg)
            scp_pkg::ST_LIT_Y: word = "y_speed:";
            scp_pkg::ST_LIT_O: word = "o_speed:";
            default:           word = "x_speed:";
        endcase
        return word[pos];
    endfunction

    function automatic logic [31:0] signed_value();
        if (ln_neg) begin
            return 32'd0 - ln_mag;
        end
        return (ln_mag > scp_pkg::POS_MAX) ? scp_pkg::POS_MAX : ln_mag;
    endfunction

    task automatic clear_line();
        ln_stage   = scp_pkg::ST_LIT_X;
        ln_lit_pos = 3'd0;
        ln_phase   = scp_pkg::PH_SKIP;
        ln_neg     = 1'b0;
        ln_mag     = '0;
        ln_x       = '0;
        ln_y       = '0;
        ln_failed  = 1'b0;
        ln_count   = 0;
        ln_cut     = 1'b0;
    endtask

    task automatic take_digit(input logic [7:0] c);
        logic [35:0] wide;
        wide     = {4'd0, ln_mag} * 36'd10 + {28'd0, c - scp_pkg::CHAR_ZERO};
        ln_mag   = (wide > {4'd0, scp_pkg::MAG_CAP}) ? scp_pkg::MAG_CAP : wide[31:0];
        ln_phase = scp_pkg::PH_DIGITS;
    endtask

    task automatic advance_parser(input logic [7:0] c);
        logic rescan;
        rescan = 1'b1;
        while (rescan) begin
            rescan = 1'b0;
            case (ln_stage)
                scp_pkg::ST_LIT_X, scp_pkg::ST_LIT_Y, scp_pkg::ST_LIT_O: begin
                    if (ln_stage == scp_pkg::ST_LIT_X || ln_lit_pos != 3'd0
                            || !is_blank(c)) begin
                        if (c != literal_at(ln_stage, ln_lit_pos)) begin
                            ln_failed = 1'b1;
                        end else if (ln_lit_pos == 3'd7) begin
                            ln_lit_pos = 3'd0;
                            ln_stage   = scp_pkg::stage_t'(ln_stage + 3'd1);
                            ln_phase   = scp_pkg::PH_SKIP;
                            ln_neg     = 1'b0;
                            ln_mag     = '0;
                        end else begin
                            ln_lit_pos = ln_lit_pos + 3'd1;
                        end
                    end
                end
                scp_pkg::ST_NUM_X, scp_pkg::ST_NUM_Y, scp_pkg::ST_NUM_O: begin
                    if (is_numeral(c)) begin
                        take_digit(c);
                    end else if (ln_phase == scp_pkg::PH_SKIP) begin
                        if (c == scp_pkg::CHAR_PLUS || c == scp_pkg::CHAR_MINUS) begin
                            ln_neg   = (c == scp_pkg::CHAR_MINUS);
                            ln_phase = scp_pkg::PH_SIGN;
                        end else if (!is_blank(c)) begin
                            ln_failed = 1'b1;
                        end
                    end else if (ln_phase == scp_pkg::PH_SIGN) begin
                        ln_failed = 1'b1;
                    end else if (ln_stage == scp_pkg::ST_NUM_O) begin
                        ln_stage = scp_pkg::ST_DONE;
                    end else begin
                        if (ln_stage == scp_pkg::ST_NUM_X) begin
                            ln_x = signed_value();
                        end else begin
                            ln_y = signed_value();
                        end
                        ln_stage   = scp_pkg::stage_t'(ln_stage + 3'd1);
                        ln_lit_pos = 3'd0;
                        rescan     = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic parse_rx_byte(input logic [7:0] c, output logic got, output logic counted,
                                 output scp_pkg::result_t r);
        got     = 1'b0;
        counted = 1'b0;
        r       = '0;
        if (c == scp_pkg::CHAR_LF || c == scp_pkg::CHAR_CR) begin
            if (ln_count > 0) begin
                counted = 1'b1;
                if (!ln_failed && (ln_stage == scp_pkg::ST_DONE
                        || (ln_stage == scp_pkg::ST_NUM_O
                            && ln_phase == scp_pkg::PH_DIGITS))) begin
                    got         = 1'b1;
                    r.x_value   = ln_x;
                    r.y_value   = ln_y;
                    r.rot_value = signed_value();
                end
                clear_line();
            end
        end else if (ln_count < BUF_BYTES - 1) begin
            counted  = 1'b1;
            ln_count = ln_count + 1;
            if (!ln_cut && !ln_failed) begin
                if (c == scp_pkg::CHAR_NUL) begin
                    ln_cut = 1'b1;
                end else begin
                    advance_parser(c);
                end
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] c);
        logic             got;
        logic             counted;
        scp_pkg::result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        parse_rx_byte(c, got, counted, r);
        if (counted) begin
            bytes_counted++;
        end
        if (got) begin
            pending_speeds.push_back(typed_active ? typed_want : r);
            results_predicted++;
        end
    endtask

    task automatic send_line();
        foreach (line_buf[i]) begin
            send_byte(line_buf[i]);
        end
        lines_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
    endtask

    task automatic add_blanks(input int lo, input int hi);
        int n;
        int pick;
        n = $urandom_range(hi, lo);
        repeat (n) begin
            pick = $urandom_range(5);
            case (pick)
                0:       line_buf.push_back(scp_pkg::CHAR_TAB);
                1:       line_buf.push_back(scp_pkg::CHAR_VT);
                2:       line_buf.push_back(scp_pkg::CHAR_FF);
                default: line_buf.push_back(scp_pkg::CHAR_SPACE);
            endcase
        end
    endtask

    task automatic add_number();
        int pick;
        int n;
        pick = $urandom_range(9);
        if (pick == 1) begin
            line_buf.push_back(scp_pkg::CHAR_PLUS);
        end else if (pick >= 7) begin
            line_buf.push_back(scp_pkg::CHAR_MINUS);
        end
        pick = $urandom_range(19);
        case (pick)
            0: add_text("2147483647");
            1: add_text("2147483648");
            2: add_text("99999999999");
            3: add_text("4294967296");
            default: begin
                n = (pick < 16) ? $urandom_range(4, 1) : $urandom_range(12, 5);
                repeat (n) line_buf.push_back(scp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
            end
        endcase
    endtask

    // long_slot picks the blank run that is made long, which can push the line past the buffer
    task automatic compose_command(input int long_slot);
        string heads [3];
        heads = '{"x_speed:", "y_speed:", "o_speed:"};
        for (int k = 0; k < 3; k++) begin
            if (k > 0) begin
                if (long_slot == 2 * k - 1) add_blanks(20, 50);
                else add_blanks(0, 2);
            end
            add_text(heads[k]);
            if (long_slot == 2 * k) add_blanks(20, 50);
            else add_blanks(0, 2);
            add_number();
        end
        if ($urandom_range(3) == 0) begin
            add_text(" trailing");
        end
    endtask

    task automatic add_line_end();
        case ($urandom_range(5))
            0:       line_buf.push_back(scp_pkg::CHAR_CR);
            1:       add_text("\r\n");
            default: line_buf.push_back(scp_pkg::CHAR_LF);
        endcase
    endtask

    task automatic compose_line();
        int kind;
        int n;
        kind = $urandom_range(99);
        line_buf.delete();
        if (kind < 62) begin
            compose_command(($urandom_range(7) == 0) ? $urandom_range(4) : -1);
        end else if (kind < 80) begin
            compose_command(-1);
            n = $urandom_range(line_buf.size() - 1);
            case ($urandom_range(2))
                0:       while (line_buf.size() > n) void'(line_buf.pop_back());
                1:       line_buf.insert(n, scp_pkg::CHAR_NUL);
                default: line_buf[n] = 8'($urandom_range(255));
            endcase
        end else if (kind < 92) begin
            n = $urandom_range(70, 1);
            repeat (n) line_buf.push_back(8'($urandom_range(255)));
        end
        add_line_end();
    endtask

    // receiver pacing, with a long hold-off on request
    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        scp_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_speeds.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result x=%0d y=%0d rot=%0d",
                             m_x_value, m_y_value, m_rot_value);
                end
            end else begin
                want = pending_speeds.pop_front();
                if (m_x_value !== want.x_value || m_y_value !== want.y_value ||
                    m_rot_value !== want.rot_value) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: expected x=%0d y=%0d rot=%0d, got x=%0d y=%0d rot=%0d",
                                 want.x_value, want.y_value, want.rot_value,
                                 m_x_value, m_y_value, m_rot_value);
                    end
                end
            end
        end
    end

    initial begin
        for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge aclk);
        $display("timeout with %0d results outstanding", pending_speeds.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int mark_bytes;
        int phase_quota;
        clear_line();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            line_buf.delete();
            add_text(row_text[i]);
            if (row_info[i].poke_at != NO_POKE) begin
                line_buf[row_info[i].poke_at] = row_info[i].poke_val;
            end
            typed_active         = row_info[i].typed;
            typed_want.x_value   = row_info[i].want_x;
            typed_want.y_value   = row_info[i].want_y;
            typed_want.rot_value = row_info[i].want_rot;
            send_line();
        end
        typed_active = 1'b0;

        // long result stall while commands keep coming
        hold_req <= hold_req + 1;
        repeat (6) begin
            line_buf.delete();
            compose_command(-1);
            add_line_end();
            send_line();
        end
        s_valid <= 1'b0;
        while (pending_speeds.size() != 0) @(posedge aclk);

        phase_quota = (ITEMS - bytes_sent) / 4;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 64; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 64; end
                default: begin send_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            mark_bytes = bytes_sent;
            while (bytes_sent - mark_bytes < phase_quota) begin
                compose_line();
                send_line();
            end
            s_valid <= 1'b0;
            while (pending_speeds.size() != 0) @(posedge aclk);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_speeds.size() != 0) begin
            $display("%0d expected results never arrived", pending_speeds.size());
            fail_count += pending_speeds.size();
        end
        $display("sent %0d lines (%0d bytes, %0d parsed) under four pacing mixes and a long stall",
                 lines_sent, bytes_sent, bytes_counted);
        $display("compared %0d of %0d predicted speed results, %0d failures",
                 results_checked, results_predicted, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
